FILE: sv/shds_pkg.sv
package shds_pkg;

   localparam int unsigned TABLE_DEPTH = 512;
   localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   localparam logic [31:0] HASH_SEED = 32'd5381;
   localparam logic [31:0] HASH_MULT = 32'd33;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       end_of_string;
   } req_payload_type;

   typedef struct packed {
      logic        already_seen;
      logic        was_added;
      logic [31:0] string_hash;
   } rsp_payload_type;

endpackage

FILE: sv/string_hash_dedup_set_top.sv
// A byte that is not last only updates the running hash and gives no item.
// A last byte gives its item after a scan of the stored hashes, which ends at the
// first match or after the last stored hash; when the table is empty, no scan is made.
// Throughput: one byte per cycle between lookups; no byte is taken during one.
// Reset: running hash to 5381, entry count to zero, no item pending; the hash
// memory is not cleared, entries at or above the count are never read.
module string_hash_dedup_set_top (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  shds_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output shds_pkg::rsp_payload_type rsp_data
);
   import shds_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [31:0] mem [TABLE_DEPTH];
   logic [31:0] mem_q_ff;

   logic [1:0]       state_ff, state_in;
   logic [31:0]      run_hash_ff, run_hash_in;
   logic [31:0]      hash_ff, hash_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic             hit_ff, hit_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_ff, rsp_in;

   logic        req_fire;
   logic [31:0] next_hash;
   logic        rd_en;
   logic        match;
   logic        out_free;
   logic        mem_we;
   logic        room;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign next_hash = run_hash_ff * HASH_MULT + {24'd0, req_data.char_byte};
   assign rd_en     = (state_ff == ST_SCAN) && (rd_idx_ff < count_ff);
   assign match     = cmp_vld_ff && (mem_q_ff == hash_ff);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign room      = (count_ff < CNT_W'(TABLE_DEPTH));
   assign mem_we    = (state_ff == ST_DONE) && out_free && !hit_ff && room;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      run_hash_in  = run_hash_ff;
      hash_in      = hash_ff;
      count_in     = count_ff;
      rd_idx_in    = rd_idx_ff;
      cmp_vld_in   = 1'b0;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_data.end_of_string) begin
                  run_hash_in = HASH_SEED;
                  hash_in     = next_hash;
                  rd_idx_in   = '0;
                  hit_in      = 1'b0;
                  state_in    = (count_ff == '0) ? ST_DONE : ST_SCAN;
               end else begin
                  run_hash_in = next_hash;
               end
            end
         end
         ST_SCAN: begin
            cmp_vld_in = rd_en;
            if (rd_en) begin
               rd_idx_in = rd_idx_ff + CNT_W'(1);
            end
            if (match) begin
               hit_in   = 1'b1;
               state_in = ST_DONE;
            end else if (!rd_en && !cmp_vld_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.already_seen = hit_ff;
               rsp_in.was_added    = mem_we;
               rsp_in.string_hash  = hash_ff;
               if (mem_we) begin
                  count_in = count_ff + CNT_W'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         run_hash_ff  <= HASH_SEED;
         count_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         run_hash_ff  <= run_hash_in;
         count_ff     <= count_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hash_ff   <= hash_in;
      rd_idx_ff <= rd_idx_in;
      hit_ff    <= hit_in;
      rsp_ff    <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[count_ff[IDX_W-1:0]] <= hash_ff;
      end
      if (rd_en) begin
         mem_q_ff <= mem[rd_idx_ff[IDX_W-1:0]];
      end
   end

`ifndef ASSERT_OFF
   a_excl_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.already_seen && rsp_ff.was_added))
      else $error("already_seen and was_added both set");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      mem_we |=> (count_ff == $past(count_ff) + CNT_W'(1)) && rsp_valid_ff
                 && rsp_ff.was_added)
      else $error("append without count step or added item");

   a_read_bound: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (rd_idx_ff < count_ff) && (state_ff == ST_SCAN))
      else $error("read of unwritten entry");
`endif

endmodule

FILE: tb/string_hash_dedup_set_checker.sv
module string_hash_dedup_set_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  shds_pkg::req_payload_type req_data,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  shds_pkg::rsp_payload_type rsp_data,
   output int unsigned               fail_count,
   output int unsigned               pending_results,
   output int unsigned               entries_held,
   output int unsigned               results_checked
);
   timeunit 1ns;
   timeprecision 1ps;
   import shds_pkg::*;

   logic [31:0]     hash_acc;
   logic [31:0]     hash_table [TABLE_DEPTH];
   int unsigned     table_fill;
   int unsigned     n_fail;
   int unsigned     n_checked;
   rsp_payload_type expected_verdicts [$];

   function automatic logic [31:0] djb2_next(input logic [31:0] acc, input logic [7:0] b);
      return acc * HASH_MULT + {24'd0, b};
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      rsp_payload_type got;
      logic [31:0]     h;
      logic            hit;
      if (reset) begin
         hash_acc   = HASH_SEED;
         table_fill = 0;
         expected_verdicts.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (expected_verdicts.size() == 0) begin
               $display("%0t: unexpected item: seen=%b added=%b hash=%h",
                        $time, got.already_seen, got.was_added, got.string_hash);
               n_fail++;
            end else begin
               want = expected_verdicts.pop_front();
               n_checked++;
               if (got.already_seen !== want.already_seen) begin
                  $display("%0t: already_seen expected %b actual %b (hash %h)",
                           $time, want.already_seen, got.already_seen, want.string_hash);
                  n_fail++;
               end
               if (got.was_added !== want.was_added) begin
                  $display("%0t: was_added expected %b actual %b (hash %h)",
                           $time, want.was_added, got.was_added, want.string_hash);
                  n_fail++;
               end
               if (got.string_hash !== want.string_hash) begin
                  $display("%0t: string_hash expected %h actual %h",
                           $time, want.string_hash, got.string_hash);
                  n_fail++;
               end
            end
         end
         if (req_valid && req_ready) begin
            h = djb2_next(hash_acc, req_data.char_byte);
            if (!req_data.end_of_string) begin
               hash_acc = h;
            end else begin
               hit = 1'b0;
               for (int unsigned i = 0; i < table_fill; i++) begin
                  if (hash_table[i] == h) hit = 1'b1;
               end
               want.already_seen = hit;
               want.was_added    = !hit && (table_fill < TABLE_DEPTH);
               want.string_hash  = h;
               if (want.was_added) begin
                  hash_table[table_fill] = h;
                  table_fill++;
               end
               expected_verdicts.push_back(want);
               hash_acc = HASH_SEED;
            end
         end
      end
      fail_count      <= n_fail;
      pending_results <= expected_verdicts.size();
      entries_held    <= table_fill;
      results_checked <= n_checked;
   end

endmodule

FILE: tb/string_hash_dedup_set_top_tb.sv
module string_hash_dedup_set_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import shds_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 3000000;
   localparam int unsigned RANDOM_BYTES = 1470;

   typedef struct packed {
      logic [95:0] body;
      logic [3:0]  len;
   } byte_run_type;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_data;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_data;

   int unsigned fail_count;
   int unsigned pending_results;
   int unsigned entries_held;
   int unsigned results_checked;

   int unsigned cycle_count = 0;
   int unsigned bytes_sent  = 0;
   int unsigned runs_sent   = 0;
   int unsigned full_runs   = 0;
   logic        calm        = 1'b0;

   byte_run_type directed_runs [$];
   byte_run_type run_history [$];

   string_hash_dedup_set_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   string_hash_dedup_set_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .fail_count      (fail_count),
      .pending_results (pending_results),
      .entries_held    (entries_held),
      .results_checked (results_checked)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("%0t: timeout, %0d items still expected", $time, pending_results);
      $display("status: fail");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(99) >= 24);
      end
   end

   function automatic byte_run_type mk_run(input int unsigned len, input logic [95:0] body);
      byte_run_type r;
      r.len  = len[3:0];
      r.body = body;
      return r;
   endfunction

   function automatic logic [7:0] rand_byte();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 10) return 8'h00;
      if (r < 15) return 8'hff;
      return 8'($urandom_range(255));
   endfunction

   // mostly two-byte strings so the table fills within the byte budget
   function automatic byte_run_type random_run();
      byte_run_type r;
      int unsigned  pick;
      int unsigned  n;
      pick = $urandom_range(99);
      if (pick < 5) n = 1;
      else if (pick < 92) n = 2;
      else n = $urandom_range(6, 3);
      r.len  = n[3:0];
      r.body = '0;
      for (int unsigned i = 0; i < n; i++) r.body[8*i +: 8] = rand_byte();
      return r;
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic last);
      while (!calm && ($urandom_range(99) < 24)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid              <= 1'b1;
      req_data.char_byte     <= b;
      req_data.end_of_string <= last;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
   endtask

   task automatic send_run(input byte_run_type r);
      for (int i = 0; i < int'(r.len); i++) begin
         send_byte(r.body[8*i +: 8], i == int'(r.len) - 1);
      end
      run_history.push_back(r);
      runs_sent++;
   endtask

   initial begin
      byte_run_type r;
      int unsigned  rand_runs;
      int unsigned  base_bytes;

      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero byte alone, 0xff, repeat of zero, zero inside a string,
      // two strings with one hash, long wrapping string, repeat of the string with the inner zero, two zero bytes
      directed_runs.push_back(mk_run(1, 96'h00));
      directed_runs.push_back(mk_run(1, 96'hff));
      directed_runs.push_back(mk_run(1, 96'h00));
      directed_runs.push_back(mk_run(3, 96'h42_00_41));
      directed_runs.push_back(mk_run(2, 96'h41_10));
      directed_runs.push_back(mk_run(2, 96'h20_11));
      directed_runs.push_back(mk_run(8, 96'hff_ff_ff_ff_ff_ff_ff_ff));
      directed_runs.push_back(mk_run(3, 96'h42_00_41));
      directed_runs.push_back(mk_run(2, 96'h00_00));
      foreach (directed_runs[i]) send_run(directed_runs[i]);

      // random part, usually runs on past a full table
      base_bytes = bytes_sent;
      rand_runs  = 0;
      while (bytes_sent - base_bytes < RANDOM_BYTES) begin
         calm = (rand_runs >= 200) && (rand_runs < 320);
         if (entries_held >= TABLE_DEPTH) full_runs++;
         if ((run_history.size() != 0) && ($urandom_range(99) < 12)) begin
            r = run_history[$urandom_range(run_history.size() - 1)];
         end else begin
            r = random_run();
         end
         send_run(r);
         rand_runs++;
      end
      calm = 1'b0;
      req_valid <= 1'b0;
      @(posedge clock);

      while (pending_results != 0) @(posedge clock);
      repeat (TABLE_DEPTH + 16) @(posedge clock);

      if (pending_results != 0) begin
         $display("%0t: %0d expected items never arrived", $time, pending_results);
      end
      $display("sent %0d strings in %0d bytes, %0d lookups checked",
               runs_sent, bytes_sent, results_checked);
      $display("table held %0d entries, %0d strings offered once it was full",
               entries_held, full_runs);
      if ((fail_count == 0) && (pending_results == 0)) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

FILE: string_hash_dedup_set_top.f
sv/shds_pkg.sv
sv/string_hash_dedup_set_top.sv
tb/string_hash_dedup_set_checker.sv
tb/string_hash_dedup_set_top_tb.sv
